// File: sv/dsse_pkg.sv
// Shared types, register codes and sine table generator for the source evaluator.
package dsse_pkg;

    localparam int CFG_DATA_BITS = 64;
    localparam int SINE_MAG_BITS = 15;

    typedef enum logic [2:0] {
        CFG_MODE        = 3'd0,
        CFG_LEVEL_A     = 3'd1,
        CFG_LEVEL_B     = 3'd2,
        CFG_PHASE_STEP  = 3'd3,
        CFG_PHASE_START = 3'd4,
        CFG_ON_TIME     = 3'd5,
        CFG_PERIOD      = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_DC     = 2'd0,
        MODE_SINE   = 2'd1,
        MODE_SQUARE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned K1  = 64'd1686629713;
    localparam longint unsigned K3  = 64'd693598668;
    localparam longint unsigned K5  = 64'd85569306;
    localparam longint unsigned K7  = 64'd5026995;
    localparam longint unsigned K9  = 64'd172272;
    localparam longint unsigned K11 = 64'd3864;

    // Q15 sine magnitude from a Q30 angle fraction of a quarter turn
    function automatic logic [SINE_MAG_BITS-1:0] sine_entry(input longint unsigned y_in);
        longint unsigned y;
        longint unsigned y2;
        longint unsigned acc;
        longint unsigned s;
        y   = (y_in >= Q30_ONE) ? (Q30_ONE - 64'd1) : y_in;
        y2  = (y * y) >> 30;
        acc = K11;
        acc = K9 - ((y2 * acc) >> 30);
        acc = K7 - ((y2 * acc) >> 30);
        acc = K5 - ((y2 * acc) >> 30);
        acc = K3 - ((y2 * acc) >> 30);
        acc = K1 - ((y2 * acc) >> 30);
        s   = (y * acc) >> 30;
        s   = (s * 64'd32767 + 64'd536870912) >> 30;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s[SINE_MAG_BITS-1:0];
    endfunction

endpackage

// File: sv/dc_sine_square_source_eval_core.sv
// DC / sine / square current source evaluator, top level.
// Throughput: one request per cycle; busy is never raised, done cannot be held off.
// Latency is set by the remainder pipeline, one quotient bit per stage.
// Reset: config returns to defaults (period 1, all else 0), pipeline empties.
module dc_sine_square_source_eval_core #(
    parameter int TIME_BITS        = 48,
    parameter int PHASE_BITS       = 32,
    parameter int LEVEL_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [TIME_BITS-1:0]                 time_now,
    output logic                                 done,
    output logic signed [LEVEL_BITS-1:0]         current_out,
    output logic                                 timing_error,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  dsse_pkg::cfg_idx_t                   cfg_index,
    input  logic [dsse_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import dsse_pkg::*;

    localparam int SINE_LAT  = 5;
    localparam int DELAY_LEN = TIME_BITS - SINE_LAT;

    mode_t                        mode_reg;
    logic signed [LEVEL_BITS-1:0] level_a_reg;
    logic signed [LEVEL_BITS-1:0] level_b_reg;
    logic [PHASE_BITS-1:0]        phase_step_reg;
    logic [15:0]                  phase_start_reg;
    logic [TIME_BITS-1:0]         on_time_reg;
    logic [TIME_BITS-1:0]         period_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_DC;
            level_a_reg     <= '0;
            level_b_reg     <= '0;
            phase_step_reg  <= '0;
            phase_start_reg <= '0;
            on_time_reg     <= '0;
            period_reg      <= TIME_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODE:        mode_reg        <= mode_t'(cfg_data[1:0]);
                CFG_LEVEL_A:     level_a_reg     <= cfg_data[LEVEL_BITS-1:0];
                CFG_LEVEL_B:     level_b_reg     <= cfg_data[LEVEL_BITS-1:0];
                CFG_PHASE_STEP:  phase_step_reg  <= cfg_data[PHASE_BITS-1:0];
                CFG_PHASE_START: phase_start_reg <= cfg_data[15:0];
                CFG_ON_TIME:     on_time_reg     <= cfg_data[TIME_BITS-1:0];
                CFG_PERIOD:      period_reg      <= cfg_data[TIME_BITS-1:0];
                default:         ;
            endcase
        end
    end

    logic                 accept;
    logic                 rem_valid;
    logic [TIME_BITS-1:0] rem;

    assign accept = start && !busy;

    dsse_rem_pipe #(
        .TIME_BITS(TIME_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .dividend (time_now),
        .divisor  (period_reg),
        .out_valid(rem_valid),
        .remainder(rem)
    );

    logic signed [LEVEL_BITS-1:0] sine_cur;

    dsse_sine_pipe #(
        .TIME_BITS       (TIME_BITS),
        .PHASE_BITS      (PHASE_BITS),
        .LEVEL_BITS      (LEVEL_BITS),
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine (
        .clk        (clk),
        .time_now   (time_now),
        .phase_step (phase_step_reg),
        .phase_start(phase_start_reg),
        .level_a    (level_a_reg),
        .level_b    (level_b_reg),
        .sine_cur   (sine_cur)
    );

    // align the sine result with the remainder
    logic signed [LEVEL_BITS-1:0] sine_dly_reg [DELAY_LEN];

    genvar d;
    generate
        for (d = 0; d < DELAY_LEN; d++)
        begin : g_dly
            always_ff @(posedge clk)
            begin
                if (d == 0)
                begin
                    sine_dly_reg[d] <= sine_cur;
                end
                else
                begin
                    sine_dly_reg[d] <= sine_dly_reg[(d == 0) ? 0 : d-1];
                end
            end
        end
    endgenerate

    logic [TIME_BITS-1:0]         on_clamp;
    logic signed [LEVEL_BITS-1:0] cur_next;
    logic                         err_next;
    logic                         done_reg;
    logic signed [LEVEL_BITS-1:0] cur_reg;
    logic                         err_reg;

    always_comb
    begin
        on_clamp = (on_time_reg > period_reg) ? period_reg : on_time_reg;
        cur_next = '0;
        err_next = 1'b0;
        unique case (mode_reg)
            MODE_DC:
            begin
                cur_next = level_a_reg;
            end
            MODE_SINE:
            begin
                cur_next = sine_dly_reg[DELAY_LEN-1];
            end
            MODE_SQUARE:
            begin
                if (period_reg == '0)
                begin
                    cur_next = level_b_reg;
                    err_next = 1'b1;
                end
                else if ((rem != '0) && (rem <= on_clamp))
                begin
                    cur_next = level_a_reg;
                end
                else
                begin
                    cur_next = level_b_reg;
                end
            end
            default:
            begin
                cur_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rem_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        err_reg <= err_next;
    end

    assign done         = done_reg;
    assign current_out  = cur_reg;
    assign timing_error = err_reg;

    // a result only ever follows a request by the full pipeline depth
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, TIME_BITS + 1))
        else $error("done without a matching request");

    // error flag only in square mode with a zero period
    a_err_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (done && timing_error) |-> (mode_reg == MODE_SQUARE && period_reg == '0))
        else $error("timing_error outside zero-period square mode");

    // a request always yields a result
    a_req_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_valid) |=> done)
        else $error("remainder result dropped");

endmodule

// File: sv/dsse_rem_pipe.sv
// Pipelined restoring remainder: one quotient bit per stage.
module dsse_rem_pipe #(
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [TIME_BITS-1:0] dividend,
    input  logic [TIME_BITS-1:0] divisor,
    output logic                 out_valid,
    output logic [TIME_BITS-1:0] remainder
);
    import dsse_pkg::*;

    logic [TIME_BITS-1:0] rem_reg [TIME_BITS];
    logic [TIME_BITS-1:0] dvd_reg [TIME_BITS];
    logic                 vld_reg [TIME_BITS];

    genvar i;
    generate
        for (i = 0; i < TIME_BITS; i++)
        begin : g_stage
            logic [TIME_BITS-1:0] rem_in;
            logic [TIME_BITS-1:0] dvd_in;
            logic                 vld_in;
            logic [TIME_BITS:0]   shifted;
            logic [TIME_BITS:0]   diff;
            logic [TIME_BITS-1:0] rem_next;

            if (i == 0)
            begin : g_first
                assign rem_in = '0;
                assign dvd_in = dividend;
                assign vld_in = in_valid;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign dvd_in = dvd_reg[i-1];
                assign vld_in = vld_reg[i-1];
            end

            always_comb
            begin
                shifted = {rem_in, dvd_in[TIME_BITS-1]};
                diff    = shifted - {1'b0, divisor};
                if (shifted >= {1'b0, divisor})
                begin
                    rem_next = diff[TIME_BITS-1:0];
                end
                else
                begin
                    rem_next = shifted[TIME_BITS-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next;
                dvd_reg[i] <= {dvd_in[TIME_BITS-2:0], 1'b0};
            end
        end
    endgenerate

    assign out_valid = vld_reg[TIME_BITS-1];
    assign remainder = rem_reg[TIME_BITS-1];

endmodule

// File: sv/dsse_sine_pipe.sv
// Five-stage sine path: phase multiply, phase sum, table read, scale, offset and clamp.
module dsse_sine_pipe #(
    parameter int TIME_BITS        = 48,
    parameter int PHASE_BITS       = 32,
    parameter int LEVEL_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                         clk,
    input  logic [TIME_BITS-1:0]         time_now,
    input  logic [PHASE_BITS-1:0]        phase_step,
    input  logic [15:0]                  phase_start,
    input  logic signed [LEVEL_BITS-1:0] level_a,
    input  logic signed [LEVEL_BITS-1:0] level_b,
    output logic signed [LEVEL_BITS-1:0] sine_cur
);
    import dsse_pkg::*;

    localparam int HB  = PHASE_BITS / 2;
    localparam int FB  = PHASE_BITS - 2;
    localparam int AW  = $clog2(SINE_TABLE_DEPTH);
    localparam int DW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW  = LEVEL_BITS + SINE_MAG_BITS + 2;
    localparam int SW  = LEVEL_BITS + 2;

    // quarter-wave table, built at elaboration
    logic [SINE_MAG_BITS-1:0] sin_rom [SINE_TABLE_DEPTH];
    genvar k;
    generate
        for (k = 0; k < SINE_TABLE_DEPTH; k++)
        begin : g_rom
            localparam longint unsigned Y =
                ((64'd2 * k + 64'd1) << 29) / SINE_TABLE_DEPTH;
            assign sin_rom[k] = sine_entry(Y);
        end
    endgenerate

    // time cut or zero-extended to the phase width; only low bits matter modulo one turn
    logic [PHASE_BITS-1:0] t_p;
    generate
        if (TIME_BITS >= PHASE_BITS)
        begin : g_tcut
            assign t_p = time_now[PHASE_BITS-1:0];
        end
        else
        begin : g_text
            assign t_p = {{(PHASE_BITS-TIME_BITS){1'b0}}, time_now};
        end
    endgenerate

    // stage A: two partial products
    logic [PHASE_BITS-1:0]    pp_lo_reg;
    logic [PHASE_BITS-HB-1:0] pp_hi_reg;
    logic [PHASE_BITS+HB-1:0] pp_lo_full;
    logic [2*PHASE_BITS-HB-1:0] pp_hi_full;

    assign pp_lo_full = (PHASE_BITS+HB)'(phase_step) * (PHASE_BITS+HB)'(t_p[HB-1:0]);
    assign pp_hi_full = (2*PHASE_BITS-HB)'(phase_step)
                      * (2*PHASE_BITS-HB)'(t_p[PHASE_BITS-1:HB]);

    always_ff @(posedge clk)
    begin
        pp_lo_reg <= pp_lo_full[PHASE_BITS-1:0];
        pp_hi_reg <= pp_hi_full[PHASE_BITS-HB-1:0];
    end

    // stage B: phase angle
    logic [PHASE_BITS-1:0] theta_reg;
    logic [PHASE_BITS-1:0] theta_next;

    assign theta_next = pp_lo_reg + {pp_hi_reg, {HB{1'b0}}}
                      + {phase_start, {(PHASE_BITS-16){1'b0}}};

    always_ff @(posedge clk)
    begin
        theta_reg <= theta_next;
    end

    // stage C: quadrant fold and table read
    logic [FB+DW-1:0]         fd;
    logic [AW-1:0]            idx;
    logic [AW-1:0]            idx_rd;
    logic [SINE_MAG_BITS-1:0] mag_reg;
    logic                     neg_reg;

    assign fd     = (FB+DW)'(theta_reg[FB-1:0]) * (FB+DW)'(SINE_TABLE_DEPTH);
    assign idx    = fd[FB+AW-1:FB];
    assign idx_rd = theta_reg[FB] ? (AW'(SINE_TABLE_DEPTH - 1) - idx) : idx;

    always_ff @(posedge clk)
    begin
        mag_reg <= sin_rom[idx_rd];
        neg_reg <= theta_reg[FB+1];
    end

    // stage D: amplitude scaling
    logic signed [SINE_MAG_BITS+1:0] s_val;
    logic signed [PW-1:0]            prod_reg;

    assign s_val = neg_reg ? -$signed({2'b00, mag_reg}) : $signed({2'b00, mag_reg});

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(level_b * s_val);
    end

    // stage E: round, add offset, clamp
    localparam logic signed [SW-1:0] MAXV = SW'((64'd1 << (LEVEL_BITS - 1)) - 64'd1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    logic signed [PW-1:0]         rounded;
    logic signed [SW-1:0]         term;
    logic signed [SW-1:0]         sum;
    logic signed [LEVEL_BITS-1:0] sat;

    always_comb
    begin
        rounded = prod_reg + PW'(1 << 14);
        term    = $signed(rounded[PW-1:15]);
        sum     = SW'(level_a) + term;
        if (sum > MAXV)
        begin
            sat = MAXV[LEVEL_BITS-1:0];
        end
        else if (sum < MINV)
        begin
            sat = MINV[LEVEL_BITS-1:0];
        end
        else
        begin
            sat = sum[LEVEL_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sine_cur <= sat;
    end

endmodule
